/* design/button_debounce_autorepeat_keymap_unit_macros.svh */
// Assertion macros shared by the keypad front end.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_KEYMAP_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_KEYMAP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDAK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDAK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bdak_pkg.sv */
// Types, constants and key map for the keypad debounce/repeat front end.
package bdak_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int MAX_EVENTS  = 6;
  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int ROLE_W      = 3;
  localparam int ROLES_W     = NUM_BUTTONS * ROLE_W;
  localparam int SLOT_W      = 3;
  localparam int KIND_W      = 2;
  localparam int KEY_W       = 4;
  localparam int MODE_W      = 3;
  localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = ROLES_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLES    = 2'd3;

  // register reset values
  localparam logic [MS_W-1:0]    DEBOUNCE_RST = 16'd50;
  localparam logic [MS_W-1:0]    FIRST_RST    = 16'd500;
  localparam logic [MS_W-1:0]    PERIOD_RST   = 16'd100;
  localparam logic [ROLES_W-1:0] ROLES_RST    = 18'd146056;

  // event kinds
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // stable level codes
  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_HIGH    = 2'd1;
  localparam logic [1:0] LVL_UNKNOWN = 2'd2;

  // roles
  localparam logic [ROLE_W-1:0] ROLE_UP    = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_DOWN  = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_LEFT  = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_RIGHT = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_OK    = 3'd4;

  // control modes
  localparam logic [MODE_W-1:0] MODE_WNAV   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NAV    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SLIDER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_KBD    = 3'd4;

  // key codes
  localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_PREV  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_NEXT  = 4'd2;
  localparam logic [KEY_W-1:0] KEY_HOME  = 4'd3;
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd4;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 4'd5;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 4'd6;
  localparam logic [KEY_W-1:0] KEY_UP    = 4'd7;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd8;
  localparam logic [KEY_W-1:0] KEY_ESC   = 4'd9;

  // one poll travelling down the cell row, gathering per-slot events
  typedef struct packed {
    logic                               valid;
    logic [TIME_W-1:0]                  now_ms;
    logic [NUM_BUTTONS-1:0]             levels;
    logic [MODE_W-1:0]                  mode;
    logic                               menu;
    logic [NUM_BUTTONS-1:0]             ev_valid;
    logic [NUM_BUTTONS-1:0][KIND_W-1:0] ev_kind;
  } poll_t;

  // timing settings broadcast to every cell
  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] first_repeat_ms;
    logic [MS_W-1:0] repeat_period_ms;
  } timing_t;

  // role to key under a mode
  function automatic logic [KEY_W-1:0] map_key(input logic [ROLE_W-1:0] role,
                                               input logic [MODE_W-1:0] mode,
                                               input logic              menu);
    logic [KEY_W-1:0] key;
    key = KEY_NONE;
    if (role > ROLE_OK || mode > MODE_KBD) begin
      key = KEY_NONE;
    end else if (role == ROLE_RIGHT && mode <= MODE_NAV && menu) begin
      key = KEY_ENTER;
    end else begin
      unique case (mode)
        MODE_WNAV: begin
          unique case (role)
            ROLE_UP:    key = KEY_PREV;
            ROLE_DOWN:  key = KEY_NEXT;
            ROLE_LEFT:  key = KEY_NONE;
            ROLE_RIGHT: key = KEY_RIGHT;
            default:    key = KEY_ENTER;
          endcase
        end
        MODE_NAV: begin
          unique case (role)
            ROLE_UP:    key = KEY_PREV;
            ROLE_DOWN:  key = KEY_NEXT;
            ROLE_LEFT:  key = KEY_HOME;
            ROLE_RIGHT: key = KEY_RIGHT;
            default:    key = KEY_ENTER;
          endcase
        end
        MODE_EDIT: begin
          unique case (role)
            ROLE_UP:    key = KEY_UP;
            ROLE_DOWN:  key = KEY_DOWN;
            ROLE_LEFT:  key = KEY_ESC;
            default:    key = KEY_ENTER;
          endcase
        end
        MODE_SLIDER: begin
          unique case (role)
            ROLE_UP:    key = KEY_RIGHT;
            ROLE_DOWN:  key = KEY_LEFT;
            ROLE_LEFT:  key = KEY_ESC;
            default:    key = KEY_ENTER;
          endcase
        end
        default: begin
          unique case (role)
            ROLE_UP:    key = KEY_UP;
            ROLE_DOWN:  key = KEY_DOWN;
            ROLE_LEFT:  key = KEY_LEFT;
            ROLE_RIGHT: key = KEY_RIGHT;
            default:    key = KEY_ENTER;
          endcase
        end
      endcase
    end
    return key;
  endfunction

endpackage

/* design/bdak_if.sv */
// Valid/ready channel interfaces for poll beats and event beats.
interface bdak_in_if import bdak_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [NUM_BUTTONS-1:0] levels;
  logic [MODE_W-1:0] key_mode;
  logic              menu_shown;

  modport source (output valid, now_ms, levels, key_mode, menu_shown, input ready);
  modport sink   (input valid, now_ms, levels, key_mode, menu_shown, output ready);
endinterface

interface bdak_out_if import bdak_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [KIND_W-1:0] event_kind;
  logic [KEY_W-1:0]  key_code;
  logic              last_event;

  modport source (output valid, slot, event_kind, key_code, last_event, input ready);
  modport sink   (input valid, slot, event_kind, key_code, last_event, output ready);
endinterface

/* design/bdak_cell.sv */
// One button slot: debounce, hold and repeat state; passes the poll on.
module bdak_cell import bdak_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  timing_t timing,
  input  poll_t   poll_in,
  output poll_t   poll_out
);

  logic [1:0]        level_r;
  logic [TIME_W-1:0] change_r;
  logic [TIME_W-1:0] deadline_r;
  logic              hold_r;
  poll_t             poll_r;

  logic              cur;
  logic              changed;
  logic              hold_eff;
  logic [TIME_W-1:0] deadline_eff;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] past_deadline;
  logic              rep;
  logic              ev;
  logic [KIND_W-1:0] kind;
  poll_t             poll_nxt;

  // this slot's sample sits at the bottom of the shifted level vector
  assign cur          = poll_in.levels[0];
  assign since_change = poll_in.now_ms - change_r;
  assign changed      = ({1'b0, cur} != level_r) &&
                        (since_change > {{(TIME_W-MS_W){1'b0}}, timing.debounce_ms});

  // a press arms the first deadline before the repeat check
  assign hold_eff     = changed ? cur : hold_r;
  assign deadline_eff = (changed && cur) ?
                        poll_in.now_ms + {{(TIME_W-MS_W){1'b0}}, timing.first_repeat_ms} :
                        deadline_r;
  assign past_deadline = poll_in.now_ms - deadline_eff;
  assign rep  = hold_eff && cur && !past_deadline[TIME_W-1];
  assign ev   = changed || rep;
  assign kind = changed ? (cur ? EV_PRESS : EV_RELEASE) : EV_REPEAT;

  // hand on: levels move down one, this slot's event enters at the top
  always_comb begin
    poll_nxt          = poll_in;
    poll_nxt.levels   = {1'b0, poll_in.levels[NUM_BUTTONS-1:1]};
    poll_nxt.ev_valid = {ev, poll_in.ev_valid[NUM_BUTTONS-1:1]};
    poll_nxt.ev_kind  = {kind, poll_in.ev_kind[NUM_BUTTONS-1:1]};
  end

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= LVL_UNKNOWN;
      change_r   <= '0;
      deadline_r <= '0;
      hold_r     <= 1'b0;
    end else if (poll_in.valid) begin
      if (changed) begin
        level_r  <= {1'b0, cur};
        change_r <= poll_in.now_ms;
      end
      hold_r     <= hold_eff;
      deadline_r <= rep ?
                    poll_in.now_ms + {{(TIME_W-MS_W){1'b0}}, timing.repeat_period_ms} :
                    deadline_eff;
    end
  end

  // stage register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r.valid <= 1'b0;
    end else begin
      poll_r <= poll_nxt;
    end
  end

  assign poll_out = poll_r;

endmodule

/* design/bdak_emit.sv */
// Event serializer: walks the gathered slot events and drives result beats.
module bdak_emit import bdak_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  poll_t              tail,
  input  logic [ROLES_W-1:0] roles,
  output logic               emit_busy,
  bdak_out_if.source         out_chan
);

  logic [NUM_BUTTONS-1:0]             pend_r;
  logic [NUM_BUTTONS-1:0][KIND_W-1:0] kind_r;
  logic [MODE_W-1:0]                  mode_r;
  logic                               menu_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic                               ov_r;
  logic [SLOT_W-1:0]                  slot_r;
  logic [KIND_W-1:0]                  okind_r;
  logic [KEY_W-1:0]                   key_r;
  logic                               last_r;

  logic [SLOT_W-1:0]      idx;
  logic [NUM_BUTTONS-1:0] pick;
  logic [NUM_BUTTONS-1:0] rest;
  logic                   take;
  logic                   last;
  logic [ROLE_W-1:0]      role;

  // lowest pending slot goes next
  always_comb begin
    idx  = '0;
    pick = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx  = SLOT_W'(i);
        pick = NUM_BUTTONS'(1) << i;
      end
    end
  end

  assign rest = pend_r & ~pick;
  assign last = (rest == '0) || (cnt_r == CNT_W'(MAX_EVENTS - 1));
  assign take = (pend_r != '0) && (!ov_r || out_chan.ready);
  assign role = roles[ROLE_W*idx +: ROLE_W];

  // pending events and per-poll context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else if (tail.valid) begin
      pend_r <= tail.ev_valid;
      cnt_r  <= '0;
    end else if (take) begin
      pend_r <= last ? '0 : rest;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      kind_r <= tail.ev_kind;
      mode_r <= tail.mode;
      menu_r <= tail.menu;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take) begin
      ov_r <= 1'b1;
    end else if (out_chan.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r  <= idx;
      okind_r <= kind_r[idx];
      key_r   <= map_key(role, mode_r, menu_r);
      last_r  <= last;
    end
  end

  assign emit_busy           = (pend_r != '0);
  assign out_chan.valid      = ov_r;
  assign out_chan.slot       = slot_r;
  assign out_chan.event_kind = okind_r;
  assign out_chan.key_code   = key_r;
  assign out_chan.last_event = last_r;

endmodule

/* design/button_debounce_autorepeat_keymap_unit.sv */
// Top level of the keypad front end: settings, cell row and event output.
// Each poll beat passes down a row of six slot cells, each with its own stage
// register, which make the debounce, press/release and typematic repeat
// decisions for the poll; the gathered events then leave through the output
// register at one beat per cycle while the output side is ready, in slot order,
// with last_event on the final one. The next poll is taken once the row and the
// serializer are empty, while the final event beat may still wait in the output
// register. Timing settings and roles are written through cfg_* and are read
// directly by the cells and the serializer, so a write also reaches a poll in flight.
module button_debounce_autorepeat_keymap_unit import bdak_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bdak_in_if.sink               in_chan,
  bdak_out_if.source            out_chan
);

`include "button_debounce_autorepeat_keymap_unit_macros.svh"

  logic [MS_W-1:0]    debounce_r;
  logic [MS_W-1:0]    first_r;
  logic [MS_W-1:0]    period_r;
  logic [ROLES_W-1:0] roles_r;

  timing_t                timing;
  poll_t [NUM_BUTTONS:0]  stage;
  logic [NUM_BUTTONS-1:0] stage_valid;
  logic                   chain_busy;
  logic                   emit_busy;
  logic                   in_acc;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      first_r    <= FIRST_RST;
      period_r   <= PERIOD_RST;
      roles_r    <= ROLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_data[MS_W-1:0];
        CFG_FIRST:    first_r    <= cfg_data[MS_W-1:0];
        CFG_PERIOD:   period_r   <= cfg_data[MS_W-1:0];
        default:      roles_r    <= cfg_data[ROLES_W-1:0];
      endcase
    end
  end

  assign timing = '{debounce_ms: debounce_r, first_repeat_ms: first_r,
                    repeat_period_ms: period_r};

  // one poll in flight at a time
  assign in_chan.ready = !chain_busy && !emit_busy;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    stage[0]          = '0;
    stage[0].valid    = in_acc;
    stage[0].now_ms   = in_chan.now_ms;
    stage[0].levels   = in_chan.levels;
    stage[0].mode     = in_chan.key_mode;
    stage[0].menu     = in_chan.menu_shown;
  end

  // row of slot cells
  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_cell
    bdak_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .timing   (timing),
      .poll_in  (stage[k]),
      .poll_out (stage[k+1])
    );
    assign stage_valid[k] = stage[k+1].valid;
  end

  assign chain_busy = (stage_valid != '0);

  bdak_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail      (stage[NUM_BUTTONS]),
    .roles     (roles_r),
    .emit_busy (emit_busy),
    .out_chan  (out_chan)
  );

  `BDAK_ASSERT_NEXT(a_accept_enters_row, in_acc, chain_busy, "accepted poll did not enter the cell row")
  `BDAK_ASSERT_SAME(a_emit_row_exclusive, emit_busy, !chain_busy, "serializer busy while a poll is in the row")
  `BDAK_ASSERT_SAME(a_single_poll, chain_busy, $onehot(stage_valid), "more than one poll in the cell row")

endmodule
